// ===== rtl/pmr_pkg.sv =====
// Shared constants and types for the periodic momentum ratio core.
// No dependencies; compiled first.
`default_nettype none

package pmr_pkg;

	localparam int MAX_PERIOD_DEF = 256;
	localparam int PERIOD_W       = 9;
	localparam int VALUE_W        = 32;
	localparam int DATE_W         = 32;
	localparam int FRAC_W         = 16;
	localparam int DIV_W          = VALUE_W + FRAC_W;
	localparam int RES_W          = DIV_W + 2;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [DATE_W-1:0]          date_t;
	typedef logic [PERIOD_W-1:0]        period_t;

	typedef struct packed {
		logic   present;
		value_t value;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/pmr_sample_if.sv =====
// Sample channel: one input word per date with valid/ready handshake.
// Depends on pmr_pkg.
`default_nettype none

interface pmr_sample_if;
	import pmr_pkg::*;

	logic   valid;
	logic   ready;
	value_t sample_value;
	logic   sample_present;
	date_t  date_stamp;

	modport source (output valid, output sample_value, output sample_present,
		output date_stamp, input ready);
	modport sink (input valid, input sample_value, input sample_present,
		input date_stamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/pmr_result_if.sv =====
// Result channel: date stamp and Q16.16 ratio with valid/ready handshake.
// Depends on pmr_pkg.
`default_nettype none

interface pmr_result_if;
	import pmr_pkg::*;

	logic   valid;
	logic   ready;
	date_t  out_date;
	value_t ratio;

	modport source (output valid, output out_date, output ratio, input ready);
	modport sink (input valid, input out_date, input ratio, output ready);
endinterface

`default_nettype wire

// ===== rtl/pmr_cfg_if.sv =====
// Configuration write channel carrying the look-back period.
// Depends on pmr_pkg.
`default_nettype none

interface pmr_cfg_if;
	import pmr_pkg::*;

	logic    valid;
	logic    ready;
	period_t period;

	modport source (output valid, output period, input ready);
	modport sink (input valid, input period, output ready);
endinterface

`default_nettype wire

// ===== rtl/periodic_momentum_ratio_core.sv =====
// Periodic momentum ratio core: history ring memory, serial divider, output register.
// Depends on pmr_pkg, pmr_sample_if, pmr_result_if, pmr_cfg_if.
//
//   channel  | dir | handshake   | word
//   samples  | in  | valid/ready | sample_value, sample_present, date_stamp
//   results  | out | valid/ready | out_date, ratio
//   cfg      | in  | valid/ready | period
//
// A word with no result passes the ring read/write, then the check.
// A word with a result passes the ring read, then the one-bit-per-cycle
// divider over the 48-bit dividend, then the output load.
// Reset clears slot, fill count and period (to 1); the ring is not cleared.
// A held result stalls the core only when the next result is ready to load.
`default_nettype none

module periodic_momentum_ratio_core #(
	parameter int MAX_PERIOD = pmr_pkg::MAX_PERIOD_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	pmr_sample_if.sink   samples,
	pmr_result_if.source results,
	pmr_cfg_if.sink      cfg
);
	import pmr_pkg::*;

	localparam int AW     = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int CNT_W  = $clog2(MAX_PERIOD + 1);
	localparam int NW     = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
	localparam int STEP_W = $clog2(DIV_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]       state_q;
	period_t          period_q;
	logic [AW-1:0]    slot_q;
	logic [CNT_W-1:0] fill_q;

	entry_t           ring_mem [MAX_PERIOD];
	entry_t           rd_q;

	value_t           now_s1;
	logic             ok_s1;
	logic             have_s1;
	date_t            date_s1;

	logic [DIV_W-1:0]   dq_q;
	logic [VALUE_W-1:0] rem_q;
	logic [VALUE_W-1:0] den_q;
	logic               neg_q;
	logic [STEP_W-1:0]  step_q;

	logic               out_valid_q;
	date_t              out_date_q;
	value_t             ratio_q;

	logic               in_acc;
	logic               cfg_acc;
	logic [NW-1:0]      per_x;
	logic [NW-1:0]      eff_n;
	logic [AW-1:0]      slot_cur;
	logic [AW-1:0]      slot_nxt;
	logic               have_w;
	logic               res_ok;
	logic [VALUE_W-1:0] now_mag;
	logic [VALUE_W-1:0] old_mag;
	logic [VALUE_W:0]   rem_sh;
	logic [VALUE_W+1:0] sub_w;
	logic signed [DIV_W:0]   q_w;
	logic signed [RES_W-1:0] r_w;
	value_t             sat_w;
	logic               load_out;

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_acc        = samples.valid && samples.ready;
	assign cfg_acc       = cfg.valid && cfg.ready;

	assign results.valid    = out_valid_q;
	assign results.out_date = out_date_q;
	assign results.ratio    = ratio_q;

	always_comb begin
		per_x = NW'(period_q);
		if (per_x == '0) begin
			eff_n = NW'(1);
		end else if (per_x > NW'(MAX_PERIOD)) begin
			eff_n = NW'(MAX_PERIOD);
		end else begin
			eff_n = per_x;
		end
		slot_cur = (NW'(slot_q) >= eff_n) ? '0 : slot_q;
		slot_nxt = ((NW'(slot_cur) + NW'(1)) >= eff_n) ? '0 : AW'(slot_cur + AW'(1));
		have_w   = (NW'(fill_q) >= eff_n);
	end

	always_comb begin
		res_ok  = have_s1 && ok_s1 && rd_q.present && (rd_q.value != '0);
		now_mag = now_s1[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(now_s1)) : $unsigned(now_s1);
		old_mag = rd_q.value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(rd_q.value))
			: $unsigned(rd_q.value);
		rem_sh  = {rem_q, dq_q[DIV_W-1]};
		sub_w   = {1'b0, rem_sh} - {2'b00, den_q};
	end

	always_comb begin
		q_w = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		r_w = RES_W'(q_w) - RES_W'(1 <<< FRAC_W);
		if (r_w > $signed(RES_W'({1'b0, {(VALUE_W-1){1'b1}}}))) begin
			sat_w = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (r_w < -$signed(RES_W'({1'b1, {(VALUE_W-1){1'b0}}}))) begin
			sat_w = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sat_w = r_w[VALUE_W-1:0];
		end
		load_out = (state_q == ST_FIN) && (!out_valid_q || results.ready);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q               <= ring_mem[slot_cur];
			ring_mem[slot_cur] <= '{present: samples.sample_present,
				value: samples.sample_value};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_s1  <= samples.sample_value;
			ok_s1   <= samples.sample_present;
			have_s1 <= have_w;
			date_s1 <= samples.date_stamp;
		end
		if (state_q == ST_READ) begin
			dq_q  <= {now_mag, FRAC_W'(0)};
			rem_q <= '0;
			den_q <= old_mag;
			neg_q <= now_s1[VALUE_W-1] ^ rd_q.value[VALUE_W-1];
		end else if (state_q == ST_DIV) begin
			dq_q  <= {dq_q[DIV_W-2:0], ~sub_w[VALUE_W+1]};
			rem_q <= sub_w[VALUE_W+1] ? rem_sh[VALUE_W-1:0] : sub_w[VALUE_W-1:0];
		end
		if (load_out) begin
			out_date_q <= date_s1;
			ratio_q    <= sat_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PERIOD_W'(1);
			slot_q      <= '0;
			fill_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				period_q <= cfg.period;
				slot_q   <= '0;
				fill_q   <= '0;
			end else if (in_acc) begin
				slot_q <= slot_nxt;
				if (!have_w) begin
					fill_q <= CNT_W'(fill_q + CNT_W'(1));
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					step_q  <= '0;
					state_q <= res_ok ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					step_q <= STEP_W'(step_q + STEP_W'(1));
					if (step_q == STEP_W'(DIV_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pmr_checker.sv =====
// Port-level assertions for periodic_momentum_ratio_core, attached by bind.
// Depends on pmr_pkg and the core's channel interfaces.
`default_nettype none

module pmr_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           in_valid,
	input wire           in_ready,
	input wire           out_valid,
	input wire           out_ready,
	input pmr_pkg::date_t  out_date,
	input pmr_pkg::value_t ratio
);
	import pmr_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input ready high right after an accepted word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_date) && $stable(ratio))
		else $error("result word changed or dropped while stalled");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_acc) && !$past(in_acc, 2))
		else $error("result appeared too soon after an accepted word");

endmodule

bind periodic_momentum_ratio_core pmr_checker u_pmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_date  (results.out_date),
	.ratio     (results.ratio)
);

`default_nettype wire
